@@ hdl/aspect_keeping_nearest_downscaler_defines.svh @@
// Assertion macros for the aspect keeping nearest downscaler.
// Included by files that carry concurrent checks; define ASSERT_OFF to drop them.
`ifndef ASPECT_KEEPING_NEAREST_DOWNSCALER_DEFINES_SVH
`define ASPECT_KEEPING_NEAREST_DOWNSCALER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/ankd_pkg.sv @@
// Shared types and constants for the aspect keeping nearest downscaler.
// No dependencies; imported by every module of the block.
package ankd_pkg;

	localparam int SIDE_W        = 13;
	localparam int TGT_W         = SIDE_W + 1;
	localparam int PIX_W         = 32;
	localparam int DVD_W         = 2 * SIDE_W;
	localparam int DCNT_W        = $clog2(DVD_W + 1);
	localparam int CFG_IDX_W     = 2;
	localparam int SIDE_CAP      = (1 << SIDE_W) - 1;
	localparam int MAX_SIDE_DEF  = 4096;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [SIDE_W-1:0] SRC_WIDTH_RST  = SIDE_W'(64);
	localparam logic [SIDE_W-1:0] SRC_HEIGHT_RST = SIDE_W'(64);
	localparam logic [SIDE_W-1:0] DIM_LIMIT_RST  = SIDE_W'(0);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DIM_LIMIT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_W_GO,
		ST_W_RUN,
		ST_H_GO,
		ST_H_RUN,
		ST_CR_GO,
		ST_CR_RUN,
		ST_RR_GO,
		ST_RR_RUN
	} setup_state_t;

	typedef struct packed {
		logic [SIDE_W-1:0] src_width;
		logic [SIDE_W-1:0] src_height;
		logic [SIDE_W-1:0] dim_limit;
		logic              wr;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic              row_end;
		logic              frame_end;
		logic [SIDE_W-1:0] width;
		logic [SIDE_W-1:0] height;
	} beat_t;

	typedef struct packed {
		logic  valid;
		beat_t beat;
	} push_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [SIDE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DVD_W-1:0]  quotient;
		logic [SIDE_W-1:0] remainder;
	} div_rsp_t;

endpackage

@@ hdl/ankd_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses ankd_pkg; shared by the front end for output size and step ratios.
module ankd_div import ankd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [SIDE_W-1:0] rem_q;
	logic [SIDE_W-1:0] dvs_q;

	logic [SIDE_W:0]   trial;
	logic [SIDE_W:0]   trial_diff;
	logic              ge;

	assign trial      = {rem_q, dvd_q[DVD_W-1]};
	assign trial_diff = trial - {1'b0, dvs_q};
	assign ge         = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DCNT_W'(1);
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? trial_diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

@@ hdl/ankd_front.sv @@
// Front end: frame setup sequencer, source scan counters and pixel selection.
// Uses ankd_pkg; drives ankd_div and pushes selected beats into ankd_queue.
module ankd_front import ankd_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [PIX_W-1:0] source_pixel,
	input  logic             q_full,
	output push_t            push,
	output div_req_t         div_req,
	input  div_rsp_t         div_rsp
);

	localparam int                CLAMP   = (MAX_SIDE > SIDE_CAP) ? SIDE_CAP : MAX_SIDE;
	localparam logic [SIDE_W-1:0] CLAMP_V = SIDE_W'(CLAMP);

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0)
			r = SIDE_W'(1);
		else if (v > CLAMP_V)
			r = CLAMP_V;
		return r;
	endfunction

	setup_state_t state_q, state_d;

	logic fresh_q, ratio_ok_q;

	logic [SIDE_W-1:0] dw_q, dh_q;
	logic [SIDE_W-1:0] col_step_q, col_rstep_q, row_step_q, row_rstep_q;

	logic [SIDE_W-1:0] col_q, row_q, dcol_q, drow_q;
	logic [TGT_W-1:0]  col_tgt_q, row_tgt_q;
	logic [SIDE_W-1:0] col_rem_q, row_rem_q;

	logic [SIDE_W-1:0] sw, sh, lim, big;
	logic              scale;
	logic [DVD_W-1:0]  prod_w, prod_h;
	logic              at_origin, size_needed, need_setup, accept;
	logic              row_hit, emit, re, fe, last_col, last_row;
	logic [SIDE_W-1:0] dcol_inc, drow_inc;
	logic [SIDE_W:0]   c_sum, c_sub, r_sum, r_sub;
	logic              c_wrap, r_wrap;
	logic [TGT_W-1:0]  col_tgt_next, row_tgt_next;
	logic [SIDE_W-1:0] div_q13;

	assign sw    = clamp_side(cfg.src_width);
	assign sh    = clamp_side(cfg.src_height);
	assign lim   = (cfg.dim_limit > CLAMP_V) ? CLAMP_V : cfg.dim_limit;
	assign big   = (sw > sh) ? sw : sh;
	assign scale = (lim != '0) && ((sw > lim) || (sh > lim));
	assign prod_w = DVD_W'(sw) * DVD_W'(lim);
	assign prod_h = DVD_W'(sh) * DVD_W'(lim);

	assign at_origin   = (col_q == '0) && (row_q == '0);
	assign size_needed = at_origin && !fresh_q;
	assign need_setup  = size_needed || !ratio_ok_q;
	assign accept      = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && size_needed)
					state_d = scale ? ST_W_GO : ST_CR_GO;
				else if (in_valid && !ratio_ok_q)
					state_d = ST_CR_GO;
			end
			ST_W_GO:   state_d = ST_W_RUN;
			ST_W_RUN:  if (div_rsp.done) state_d = ST_H_GO;
			ST_H_GO:   state_d = ST_H_RUN;
			ST_H_RUN:  if (div_rsp.done) state_d = ST_CR_GO;
			ST_CR_GO:  state_d = ST_CR_RUN;
			ST_CR_RUN: if (div_rsp.done) state_d = ST_RR_GO;
			ST_RR_GO:  state_d = ST_RR_RUN;
			ST_RR_RUN: if (div_rsp.done) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
		if (cfg.wr)
			state_d = ST_IDLE;
	end

	// outputs
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = big;
		case (state_q)
			ST_W_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_w;
			end
			ST_H_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_h;
			end
			ST_CR_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(sw);
				div_req.divisor  = dw_q;
			end
			ST_RR_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(sh);
				div_req.divisor  = dh_q;
			end
			default: ;
		endcase
		in_stall = !((state_q == ST_IDLE) && !need_setup && !q_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fresh_q    <= 1'b0;
			ratio_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.wr) begin
				fresh_q    <= 1'b0;
				ratio_ok_q <= 1'b0;
			end else if (accept) begin
				fresh_q <= 1'b0;
			end else if (state_q == ST_RR_RUN && div_rsp.done) begin
				fresh_q    <= 1'b1;
				ratio_ok_q <= 1'b1;
			end
		end
	end

	// quotient of an output size division, at least 1
	assign div_q13 = (div_rsp.quotient == '0) ? SIDE_W'(1) : div_rsp.quotient[SIDE_W-1:0];

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && state_d == ST_CR_GO && size_needed) begin
			dw_q <= sw;
			dh_q <= sh;
		end
		if (state_q == ST_W_RUN && div_rsp.done)
			dw_q <= div_q13;
		if (state_q == ST_H_RUN && div_rsp.done)
			dh_q <= div_q13;
		if (state_q == ST_CR_RUN && div_rsp.done) begin
			col_step_q  <= div_rsp.quotient[SIDE_W-1:0];
			col_rstep_q <= div_rsp.remainder;
		end
		if (state_q == ST_RR_RUN && div_rsp.done) begin
			row_step_q  <= div_rsp.quotient[SIDE_W-1:0];
			row_rstep_q <= div_rsp.remainder;
		end
	end

	// per-pixel selection
	assign row_hit  = ({1'b0, row_q} == row_tgt_q) && (drow_q < dh_q);
	assign emit     = row_hit && ({1'b0, col_q} == col_tgt_q) && (dcol_q < dw_q);
	assign dcol_inc = dcol_q + SIDE_W'(1);
	assign drow_inc = drow_q + SIDE_W'(1);
	assign re       = (dcol_inc == dw_q);
	assign fe       = re && (drow_inc == dh_q);
	assign last_col = ({1'b0, col_q} + TGT_W'(1)) >= {1'b0, sw};
	assign last_row = ({1'b0, row_q} + TGT_W'(1)) >= {1'b0, sh};

	assign c_sum  = {1'b0, col_rem_q} + {1'b0, col_rstep_q};
	assign c_sub  = c_sum - {1'b0, dw_q};
	assign c_wrap = c_sum >= {1'b0, dw_q};
	assign col_tgt_next = col_tgt_q + TGT_W'(col_step_q) + TGT_W'(c_wrap);

	assign r_sum  = {1'b0, row_rem_q} + {1'b0, row_rstep_q};
	assign r_sub  = r_sum - {1'b0, dh_q};
	assign r_wrap = r_sum >= {1'b0, dh_q};
	assign row_tgt_next = row_tgt_q + TGT_W'(row_step_q) + TGT_W'(r_wrap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			dcol_q    <= '0;
			drow_q    <= '0;
			col_tgt_q <= '0;
			row_tgt_q <= '0;
			col_rem_q <= '0;
			row_rem_q <= '0;
		end else if (accept) begin
			if (emit) begin
				dcol_q    <= dcol_inc;
				col_tgt_q <= col_tgt_next;
				col_rem_q <= c_wrap ? c_sub[SIDE_W-1:0] : c_sum[SIDE_W-1:0];
			end
			if (!last_col) begin
				col_q <= col_q + SIDE_W'(1);
			end else begin
				col_q     <= '0;
				dcol_q    <= '0;
				col_tgt_q <= '0;
				col_rem_q <= '0;
				if (last_row) begin
					row_q     <= '0;
					drow_q    <= '0;
					row_tgt_q <= '0;
					row_rem_q <= '0;
				end else begin
					if (row_hit) begin
						drow_q    <= drow_inc;
						row_tgt_q <= row_tgt_next;
						row_rem_q <= r_wrap ? r_sub[SIDE_W-1:0] : r_sum[SIDE_W-1:0];
					end
					row_q <= row_q + SIDE_W'(1);
				end
			end
		end
	end

	assign push.valid          = accept && emit;
	assign push.beat.pixel     = source_pixel;
	assign push.beat.row_end   = re;
	assign push.beat.frame_end = fe;
	assign push.beat.width     = dw_q;
	assign push.beat.height    = dh_q;

endmodule

@@ hdl/ankd_queue.sv @@
// Back end: short beat queue that decouples pixel selection from the output port.
// Uses ankd_pkg; fed by ankd_front.
module ankd_queue import ankd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	output logic  out_valid,
	input  logic  out_stall,
	output beat_t out_beat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	beat_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign pop       = out_valid && !out_stall;
	assign out_beat  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_ptr_q] <= push.beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push.valid && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push.valid)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

@@ hdl/aspect_keeping_nearest_downscaler.sv @@
// Top level of the aspect keeping nearest downscaler: config registers and wiring.
// Uses ankd_pkg, ankd_div, ankd_front, ankd_queue and the assertion macro header.
//
//  channel   dir  handshake              payload
//  in        in   in_valid / in_stall    source_pixel
//  out       out  out_valid / out_stall  output_pixel, row_end, frame_end,
//                                        output_width, output_height
//  cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per clock within a frame while in_stall is low. At the first pixel of each
// frame the shared serial divider computes output size (when scaling) and step ratios,
// one bit a cycle; at the next pixel after any config write it recomputes the step ratios.
// Reset is asynchronous; no clearing pass. out_stall backs up into a four beat
// queue before in_stall rises.
`include "aspect_keeping_nearest_downscaler_defines.svh"

module aspect_keeping_nearest_downscaler import ankd_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	parameter int QDEPTH   = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIDE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     source_pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     output_pixel,
	output logic                 row_end,
	output logic                 frame_end,
	output logic [SIDE_W-1:0]    output_width,
	output logic [SIDE_W-1:0]    output_height
);

	logic [SIDE_W-1:0] src_width_q, src_height_q, dim_limit_q;
	cfg_t              cfg;
	push_t             push;
	logic              q_full;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	beat_t             out_beat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
			dim_limit_q  <= DIM_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				REG_DIM_LIMIT:  dim_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.src_width  = src_width_q;
	assign cfg.src_height = src_height_q;
	assign cfg.dim_limit  = dim_limit_q;
	assign cfg.wr         = cfg_valid && cfg_ready;

	ankd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ankd_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.source_pixel (source_pixel),
		.q_full       (q_full),
		.push         (push),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

	ankd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	assign output_pixel  = out_beat.pixel;
	assign row_end       = out_beat.row_end;
	assign frame_end     = out_beat.frame_end;
	assign output_width  = out_beat.width;
	assign output_height = out_beat.height;

	`ASSERT_HOLDS(a_no_accept_full, clk, arst_n, in_valid && !in_stall, !q_full)
	`ASSERT_NEXT(a_cfg_forces_setup, clk, arst_n, cfg_valid && cfg_ready, in_stall)
	`ASSERT_HOLDS(a_frame_end_row_end, clk, arst_n, out_valid && frame_end, row_end)
	`ASSERT_HOLDS(a_size_nonzero, clk, arst_n, out_valid, output_width != '0 && output_height != '0)

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for aspect_keeping_nearest_downscaler: a pixel tracker class predicts
// kept pixels and frame sizes, random idling on both channels. Needs ankd_pkg and the RTL.
module tb_top;
	import ankd_pkg::*;

	localparam int HANG_LIMIT      = 2000;
	localparam int DIVIDER_SLACK   = 160;
	localparam int OVERSIZE_PIXELS = 100;
	localparam int RANDOM_PIXELS   = 420;

	class downscale_tracker;
		logic [SIDE_W-1:0] src_width, src_height, dim_limit;
		int unsigned       col, row, out_col, out_row, col_rem, row_rem, out_w, out_h;
		int unsigned       col_tgt, row_tgt;
		beat_t             kept_pixels[$];
		int                failures;

		function new();
			src_width  = SRC_WIDTH_RST;
			src_height = SRC_HEIGHT_RST;
			dim_limit  = DIM_LIMIT_RST;
			col = 0; row = 0; out_col = 0; out_row = 0;
			col_rem = 0; row_rem = 0; col_tgt = 0; row_tgt = 0;
			out_w = 1; out_h = 1;
			failures = 0;
		endfunction

		function int unsigned side_of(logic [SIDE_W-1:0] v);
			if (v == 0) return 1;
			if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
			return v;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [SIDE_W-1:0] v);
			case (idx)
				REG_SRC_WIDTH:  src_width = v;
				REG_SRC_HEIGHT: src_height = v;
				REG_DIM_LIMIT:  dim_limit = v;
				default: ;
			endcase
		endfunction

		function void take_pixel(logic [PIX_W-1:0] pix);
			int unsigned sw, sh, lim, big, q, acc;
			bit          row_hit, fire;
			beat_t       b;
			sw = side_of(src_width);
			sh = side_of(src_height);
			// output size is fixed at the first pixel of a frame
			if (col == 0 && row == 0) begin
				lim = (dim_limit > MAX_SIDE_DEF) ? MAX_SIDE_DEF : dim_limit;
				out_w = sw;
				out_h = sh;
				if (lim != 0 && (sw > lim || sh > lim)) begin
					big = (sw > sh) ? sw : sh;
					q = sw * lim / big;
					out_w = (q < 1) ? 1 : q;
					q = sh * lim / big;
					out_h = (q < 1) ? 1 : q;
				end
			end
			row_hit = (row == row_tgt) && (out_row < out_h);
			fire = row_hit && (col == col_tgt) && (out_col < out_w);
			if (fire) begin
				b.pixel     = pix;
				b.row_end   = (out_col + 1 == out_w);
				b.frame_end = b.row_end && (out_row + 1 == out_h);
				b.width     = SIDE_W'(out_w);
				b.height    = SIDE_W'(out_h);
				kept_pixels.push_back(b);
				out_col++;
				acc = col_rem + sw % out_w;
				col_tgt += sw / out_w;
				if (acc >= out_w) begin
					acc -= out_w;
					col_tgt++;
				end
				col_rem = acc;
			end
			if (col + 1 < sw) begin
				col++;
				return;
			end
			col = 0; out_col = 0; col_tgt = 0; col_rem = 0;
			if (row + 1 >= sh) begin
				row = 0; out_row = 0; row_tgt = 0; row_rem = 0;
				return;
			end
			if (row_hit) begin
				out_row++;
				acc = row_rem + sh % out_h;
				row_tgt += sh / out_h;
				if (acc >= out_h) begin
					acc -= out_h;
					row_tgt++;
				end
				row_rem = acc;
			end
			row++;
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (kept_pixels.size() == 0) begin
				if (failures < 10)
					$display("%0t: unexpected beat, pixel %h", $realtime, got.pixel);
				failures++;
				return;
			end
			want = kept_pixels.pop_front();
			if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
					got.frame_end !== want.frame_end || got.width !== want.width ||
					got.height !== want.height) begin
				if (failures < 10)
					$display("%0t: beat mismatch (got/exp) pixel %h/%h row_end %b/%b ",
						$realtime, got.pixel, want.pixel, got.row_end, want.row_end,
						"frame_end %b/%b size %0dx%0d/%0dx%0d",
						got.frame_end, want.frame_end, got.width, got.height,
						want.width, want.height);
				failures++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIDE_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [PIX_W-1:0]     source_pixel;
	logic                 out_valid;
	logic                 out_stall;
	logic [PIX_W-1:0]     output_pixel;
	logic                 row_end;
	logic                 frame_end;
	logic [SIDE_W-1:0]    output_width;
	logic [SIDE_W-1:0]    output_height;

	downscale_tracker sb;
	int               tx_gap_max;
	int               rx_stall_max;

	aspect_keeping_nearest_downscaler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.source_pixel  (source_pixel),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.output_pixel  (output_pixel),
		.row_end       (row_end),
		.frame_end     (frame_end),
		.output_width  (output_width),
		.output_height (output_height)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// output side: random stall after every beat
	initial begin : sink
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
				sb.check_beat({output_pixel, row_end, frame_end, output_width, output_height});
				stall_left = $urandom_range(0, rx_stall_max);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic push_pixel(logic [PIX_W-1:0] pix);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		source_pixel <= pix;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.take_pixel(pix);
	endtask

	task automatic wait_for_output();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.kept_pixels.size() != 0);
	endtask

	task automatic write_regs(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h,
			logic [SIDE_W-1:0] lim);
		cfg_reg_t          idx[3];
		logic [SIDE_W-1:0] val[3];
		idx = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DIM_LIMIT};
		val = '{w, h, lim};
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sb.write_reg(idx[k], val[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	// settle, reprogram, then stream count pixels; count may stop mid-frame
	task automatic run_phase(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h,
			logic [SIDE_W-1:0] lim, int count);
		logic [PIX_W-1:0] pix;
		wait_for_output();
		repeat (DIVIDER_SLACK) @(posedge clk);
		write_regs(w, h, lim);
		tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
		rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
		for (int i = 0; i < count; i++) begin
			pix = $urandom();
			if (i == 0)
				pix = '0;
			else if (i == 1)
				pix = '1;
			if (i > 0 && $urandom_range(0, 49) == 0)
				wait_for_output();
			push_pixel(pix);
		end
	endtask

	initial begin : stimulus
		logic [SIDE_W-1:0] w, h, lim;
		int                n, sent;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SRC_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		source_pixel = '0;
		tx_gap_max = 0;
		rx_stall_max = 0;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// limit equal to the larger side: pass-through
		run_phase(13'd3, 13'd2, 13'd3, 6);
		// zero sizes act as one
		run_phase(13'd0, 13'd0, 13'd0, 2);
		// stop mid-frame, then reprogram
		run_phase(13'd4, 13'd4, 13'd2, 6);
		// scaled frame whose height floors to zero and is held at one
		run_phase(13'd5, 13'd2, 13'd2, 13);

		// oversize width, oversize limit, oversize height with limit one
		run_phase(13'h1FFF, 13'd1, 13'd16, OVERSIZE_PIXELS);
		run_phase(13'd4096, 13'd1, 13'h1FFF, OVERSIZE_PIXELS);
		run_phase(13'd1, 13'h1FFF, 13'd1, OVERSIZE_PIXELS);

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			w = SIDE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) :
				$urandom_range(0, 12));
			h = SIDE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) :
				$urandom_range(0, 12));
			case ($urandom_range(0, 3))
				0: lim = '0;
				1: lim = SIDE_W'($urandom_range(1, 12));
				2: lim = SIDE_W'($urandom_range(1, 24));
				default: lim = SIDE_W'($urandom_range(0, 8191));
			endcase
			n = sb.side_of(w) * sb.side_of(h) * $urandom_range(1, 2);
			if ($urandom_range(0, 7) == 0)
				n = $urandom_range(1, n);
			if (n > RANDOM_PIXELS - sent)
				n = RANDOM_PIXELS - sent;
			run_phase(w, h, lim, n);
			sent += n;
		end

		wait_for_output();
		repeat (DIVIDER_SLACK) @(posedge clk);
		sb.failures += sb.kept_pixels.size();
		if (sb.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
